/* hdl/ols_pkg.sv */
`timescale 1ns / 1ps

package ols_pkg;

    // Defaults for the top-level parameters.
    localparam int DEPTH_DEF       = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    // Fixed widths of the request and result fields.
    localparam int KIND_W     = 3;
    localparam int VAL_IO_W   = 32;
    localparam int POS_W      = 4;
    localparam int STATUS_W   = 3;
    localparam int COUNT_IO_W = 5;

    // Width of the cell select broadcast along the chain; covers the deepest list.
    localparam int SEL_W = 8;

    typedef enum logic [KIND_W-1:0] {
        K_PUSH_BACK  = 3'd0,
        K_PUSH_FRONT = 3'd1,
        K_POP_FRONT  = 3'd2,
        K_CONTAINS   = 3'd3,
        K_REMOVE     = 3'd4,
        K_READ       = 3'd5
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_RANGE     = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        CELL_HOLD       = 3'd0,
        CELL_PUSH_BACK  = 3'd1,
        CELL_PUSH_FRONT = 3'd2,
        CELL_SHIFT_LEFT = 3'd3,
        CELL_ROTATE     = 3'd4
    } t_cell_op;

    typedef struct packed {
        t_cell_op         op;
        logic [SEL_W-1:0] tgt;
    } t_cell_ctl;

endpackage

/* hdl/ols_cell.sv */
`timescale 1ns / 1ps

module ols_cell #(
    parameter int VALUE_WIDTH = ols_pkg::VALUE_WIDTH_DEF,
    parameter int IDX         = 0
) (
    input  logic                   i_clk,
    input  ols_pkg::t_cell_ctl     i_ctl,
    input  logic [VALUE_WIDTH-1:0] i_data,
    input  logic [VALUE_WIDTH-1:0] i_left,
    input  logic [VALUE_WIDTH-1:0] i_right,
    output logic [VALUE_WIDTH-1:0] o_value
);

    logic [VALUE_WIDTH-1:0] r_value;
    logic [VALUE_WIDTH-1:0] n_value;
    logic                   w_sel;

    assign w_sel = (i_ctl.tgt == ols_pkg::SEL_W'(IDX));

    always_comb begin
        n_value = r_value;
        unique case (i_ctl.op)
            ols_pkg::CELL_HOLD: begin
                n_value = r_value;
            end
            ols_pkg::CELL_PUSH_BACK: begin
                if (w_sel) begin
                    n_value = i_data;
                end
            end
            ols_pkg::CELL_PUSH_FRONT: begin
                n_value = (IDX == 0) ? i_data : i_left;
            end
            ols_pkg::CELL_SHIFT_LEFT: begin
                n_value = i_right;
            end
            ols_pkg::CELL_ROTATE: begin
                // The old head is written back at the tail, everything else moves forward.
                n_value = w_sel ? i_data : i_right;
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

/* hdl/ordered_list_store.sv */
`timescale 1ns / 1ps

// Ordered list of up to DEPTH values held in a chain of cells, front at position 0.
// A request is taken when start is high and busy is low; its result appears on the
// o_ ports, marked by o_done for exactly one cycle, and must be taken in that cycle
// since the receiver cannot stall the block. Push back, push front, pop front, read at
// index and undefined kinds need no scan: o_done follows in the next cycle and
// busy stays low, so these requests can be issued every cycle. Contains and remove
// rotate the list once through the cell chain, one entry per cycle at the head cell,
// so they hold busy high until every entry held before the request has passed the
// head; o_done follows the last step. An empty list gives status empty without a scan.
// o_entry_count is the count after the request, in its low five bits.
module ordered_list_store #(
    parameter int DEPTH       = ols_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = ols_pkg::VALUE_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    input  logic [ols_pkg::KIND_W-1:0]        i_kind,
    input  logic [ols_pkg::VAL_IO_W-1:0]      i_value,
    input  logic [ols_pkg::POS_W-1:0]         i_position,
    output logic                              busy,
    output logic                              o_done,
    output logic [ols_pkg::STATUS_W-1:0]      o_status,
    output logic                              o_found,
    output logic [ols_pkg::VAL_IO_W-1:0]      o_read_value,
    output logic [ols_pkg::COUNT_IO_W-1:0]    o_entry_count
);

    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int RD_SPAN = (DEPTH < (1 << ols_pkg::POS_W)) ? DEPTH : (1 << ols_pkg::POS_W);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state                        r_state, n_state;
    logic [CNT_W-1:0]              r_count, n_count;
    logic [CNT_W-1:0]              r_len, n_len;
    logic [CNT_W-1:0]              r_step, n_step;
    logic                          r_hit, n_hit;
    logic                          r_remove, n_remove;
    logic [VALUE_WIDTH-1:0]        r_key, n_key;
    logic                          r_done, n_done;
    ols_pkg::t_status              r_status, n_status;
    logic                          r_found, n_found;
    logic [ols_pkg::VAL_IO_W-1:0]  r_rd, n_rd;

    logic [VALUE_WIDTH-1:0]        w_val [DEPTH];
    logic [VALUE_WIDTH-1:0]        w_key;
    logic [VALUE_WIDTH-1:0]        w_data;
    logic [VALUE_WIDTH-1:0]        w_rd_sel;
    ols_pkg::t_cell_ctl            w_ctl;
    logic                          w_accept;
    logic                          w_full;
    logic                          w_match;
    logic                          w_drop;

    assign busy     = (r_state == S_SCAN);
    assign w_accept = start && !busy;
    assign w_key    = VALUE_WIDTH'(i_value);
    assign w_full   = (r_count == CNT_W'(DEPTH));

    // Read port: only the cells that the POS_W-bit position field can index are reachable.
    always_comb begin
        w_rd_sel = '0;
        for (int i = 0; i < RD_SPAN; i++) begin
            if (i_position == ols_pkg::POS_W'(i)) begin
                w_rd_sel = w_val[i];
            end
        end
    end

    assign w_match = (w_val[0] == r_key) && !r_hit;
    assign w_drop  = w_match && r_remove;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_len      = r_len;
        n_step     = r_step;
        n_hit      = r_hit;
        n_remove   = r_remove;
        n_key      = r_key;
        n_done     = 1'b0;
        n_status   = r_status;
        n_found    = r_found;
        n_rd       = r_rd;
        w_ctl.op   = ols_pkg::CELL_HOLD;
        w_ctl.tgt  = '0;
        w_data     = w_key;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_done   = 1'b1;
                    n_status = ols_pkg::ST_OK;
                    n_found  = 1'b0;
                    n_rd     = '0;
                    unique case (i_kind)
                        ols_pkg::K_PUSH_BACK: begin
                            if (w_full) begin
                                n_status = ols_pkg::ST_FULL;
                            end else begin
                                w_ctl.op  = ols_pkg::CELL_PUSH_BACK;
                                w_ctl.tgt = ols_pkg::SEL_W'(r_count);
                                n_count   = r_count + CNT_W'(1);
                            end
                        end
                        ols_pkg::K_PUSH_FRONT: begin
                            if (w_full) begin
                                n_status = ols_pkg::ST_FULL;
                            end else begin
                                w_ctl.op = ols_pkg::CELL_PUSH_FRONT;
                                n_count  = r_count + CNT_W'(1);
                            end
                        end
                        ols_pkg::K_POP_FRONT: begin
                            if (r_count == '0) begin
                                n_status = ols_pkg::ST_EMPTY;
                            end else begin
                                w_ctl.op = ols_pkg::CELL_SHIFT_LEFT;
                                n_count  = r_count - CNT_W'(1);
                            end
                        end
                        ols_pkg::K_CONTAINS, ols_pkg::K_REMOVE: begin
                            if (r_count == '0) begin
                                n_status = ols_pkg::ST_EMPTY;
                            end else begin
                                n_done   = 1'b0;
                                n_state  = S_SCAN;
                                n_key    = w_key;
                                n_remove = (i_kind == ols_pkg::K_REMOVE);
                                n_len    = r_count;
                                n_step   = r_count;
                                n_hit    = 1'b0;
                            end
                        end
                        ols_pkg::K_READ: begin
                            if ((CNT_W + ols_pkg::POS_W)'(i_position) >=
                                (CNT_W + ols_pkg::POS_W)'(r_count)) begin
                                n_status = ols_pkg::ST_RANGE;
                            end else begin
                                n_rd = ols_pkg::VAL_IO_W'(w_rd_sel);
                            end
                        end
                        default: begin
                            n_status = ols_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // Each step takes the head entry; a kept entry goes back in at the tail,
                // the first match of a remove is simply left out.
                if (w_drop) begin
                    w_ctl.op = ols_pkg::CELL_SHIFT_LEFT;
                    n_len    = r_len - CNT_W'(1);
                end else begin
                    w_ctl.op  = ols_pkg::CELL_ROTATE;
                    w_ctl.tgt = ols_pkg::SEL_W'(r_len - CNT_W'(1));
                    w_data    = w_val[0];
                end
                n_hit  = r_hit || w_match;
                n_step = r_step - CNT_W'(1);
                if (r_step == CNT_W'(1)) begin
                    n_state  = S_IDLE;
                    n_done   = 1'b1;
                    n_found  = n_hit;
                    n_status = n_hit ? ols_pkg::ST_OK : ols_pkg::ST_NOT_FOUND;
                    n_rd     = '0;
                    n_count  = n_len;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_len    <= '0;
            r_step   <= '0;
            r_hit    <= 1'b0;
            r_remove <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_len    <= n_len;
            r_step   <= n_step;
            r_hit    <= n_hit;
            r_remove <= n_remove;
            r_done   <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_status <= n_status;
        r_found  <= n_found;
        r_rd     <= n_rd;
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [VALUE_WIDTH-1:0] w_left;
        logic [VALUE_WIDTH-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = w_data;
        end else begin : g_inner_l
            assign w_left = w_val[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right = w_val[g];
        end else begin : g_inner_r
            assign w_right = w_val[g+1];
        end

        ols_cell #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .IDX         (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_data  (w_data),
            .i_left  (w_left),
            .i_right (w_right),
            .o_value (w_val[g])
        );
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_found       = r_found;
    assign o_read_value  = r_rd;
    assign o_entry_count = ols_pkg::COUNT_IO_W'(r_count);

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count exceeds depth");

    a_scan_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_len <= r_count && r_step <= r_len))
        else $error("scan length out of step with entry count");

    a_quick_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_kind != ols_pkg::K_CONTAINS && i_kind != ols_pkg::K_REMOVE)
        |=> o_done)
        else $error("single-cycle request gave no result");

    a_push_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_kind == ols_pkg::K_PUSH_FRONT && !w_full)
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("push front did not grow the list");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_found) |-> (o_status == ols_pkg::ST_OK))
        else $error("found flag with error status");
`endif

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;

    localparam int DEPTH       = ols_pkg::DEPTH_DEF;
    localparam int CYCLE_LIMIT = 300000;
    localparam int TAIL_CYCLES = 40;
    localparam int RAND_ITEMS  = 450;
    localparam int CHUNK       = 50;

    // Kind codes outside the defined set; the block must treat them as no-ops.
    localparam logic [ols_pkg::KIND_W-1:0] KIND_UNDEF_LO = 3'd6;
    localparam logic [ols_pkg::KIND_W-1:0] KIND_UNDEF_HI = 3'd7;

    typedef struct {
        logic [ols_pkg::KIND_W-1:0]   kind;
        logic [ols_pkg::VAL_IO_W-1:0] value;
        logic [ols_pkg::POS_W-1:0]    position;
        int                           gap;
        bit                           drain;
    } t_list_req;

    typedef struct {
        ols_pkg::t_status               status;
        logic                           found;
        logic [ols_pkg::VAL_IO_W-1:0]   read_value;
        logic [ols_pkg::COUNT_IO_W-1:0] entry_count;
    } t_list_result;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           start = 1'b0;
    logic [ols_pkg::KIND_W-1:0]     i_kind = '0;
    logic [ols_pkg::VAL_IO_W-1:0]   i_value = '0;
    logic [ols_pkg::POS_W-1:0]      i_position = '0;
    logic                           busy;
    logic                           o_done;
    logic [ols_pkg::STATUS_W-1:0]   o_status;
    logic                           o_found;
    logic [ols_pkg::VAL_IO_W-1:0]   o_read_value;
    logic [ols_pkg::COUNT_IO_W-1:0] o_entry_count;

    t_list_req    pending_requests[$];
    t_list_result expected_results[$];
    logic [ols_pkg::VAL_IO_W-1:0] list_shadow[DEPTH];
    int           list_size = 0;
    logic [ols_pkg::VAL_IO_W-1:0] value_pool[8];

    bit req_taken = 1'b0;
    int accepted_cnt = 0;
    int checked_cnt = 0;
    int mismatch_cnt = 0;
    int cycle_cnt = 0;
    int status_seen[5];
    int kind_seen[8];

    ordered_list_store dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_kind       (i_kind),
        .i_value      (i_value),
        .i_position   (i_position),
        .busy         (busy),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_found      (o_found),
        .o_read_value (o_read_value),
        .o_entry_count(o_entry_count)
    );

    always #5 i_clk = ~i_clk;

    // Applies one request to the shadow list and returns the result it must produce.
    function automatic t_list_result apply_list_request(t_list_req rq);
        t_list_result r;
        int hit;
        r.status = ols_pkg::ST_OK;
        r.found = 1'b0;
        r.read_value = '0;
        hit = -1;
        if (rq.kind == ols_pkg::K_CONTAINS || rq.kind == ols_pkg::K_REMOVE) begin
            for (int i = 0; i < list_size; i++) begin
                if (hit < 0 && list_shadow[i] == rq.value) begin
                    hit = i;
                end
            end
        end
        case (rq.kind)
            ols_pkg::K_PUSH_BACK: begin
                if (list_size >= DEPTH) begin
                    r.status = ols_pkg::ST_FULL;
                end else begin
                    list_shadow[list_size] = rq.value;
                    list_size++;
                end
            end
            ols_pkg::K_PUSH_FRONT: begin
                if (list_size >= DEPTH) begin
                    r.status = ols_pkg::ST_FULL;
                end else begin
                    for (int i = list_size; i > 0; i--) begin
                        list_shadow[i] = list_shadow[i-1];
                    end
                    list_shadow[0] = rq.value;
                    list_size++;
                end
            end
            ols_pkg::K_POP_FRONT: begin
                if (list_size == 0) begin
                    r.status = ols_pkg::ST_EMPTY;
                end else begin
                    for (int i = 0; i < list_size - 1; i++) begin
                        list_shadow[i] = list_shadow[i+1];
                    end
                    list_size--;
                end
            end
            ols_pkg::K_CONTAINS: begin
                if (list_size == 0) begin
                    r.status = ols_pkg::ST_EMPTY;
                end else if (hit >= 0) begin
                    r.found = 1'b1;
                end else begin
                    r.status = ols_pkg::ST_NOT_FOUND;
                end
            end
            ols_pkg::K_REMOVE: begin
                if (list_size == 0) begin
                    r.status = ols_pkg::ST_EMPTY;
                end else if (hit < 0) begin
                    r.status = ols_pkg::ST_NOT_FOUND;
                end else begin
                    for (int i = hit; i < list_size - 1; i++) begin
                        list_shadow[i] = list_shadow[i+1];
                    end
                    list_size--;
                    r.found = 1'b1;
                end
            end
            ols_pkg::K_READ: begin
                if (int'(rq.position) >= list_size) begin
                    r.status = ols_pkg::ST_RANGE;
                end else begin
                    r.read_value = list_shadow[rq.position];
                end
            end
            default: begin
            end
        endcase
        r.entry_count = list_size[ols_pkg::COUNT_IO_W-1:0];
        return r;
    endfunction

    // Mostly back-to-back, sometimes a short gap, rarely a long pause.
    function automatic int rand_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) begin
            return 0;
        end else if (p < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 40);
    endfunction

    function automatic logic [ols_pkg::VAL_IO_W-1:0] pick_value();
        if ($urandom_range(0, 99) < 75) begin
            return value_pool[$urandom_range(0, 7)];
        end
        return $urandom();
    endfunction

    // Growing phases favor inserts, shrinking phases favor pops and removals.
    function automatic logic [ols_pkg::KIND_W-1:0] pick_kind(bit grow);
        int p;
        p = $urandom_range(0, 99);
        if (p < 5) begin
            return ($urandom_range(0, 1) != 0) ? KIND_UNDEF_HI : KIND_UNDEF_LO;
        end else if (p < 22) begin
            return ols_pkg::K_READ;
        end else if (p < 37) begin
            return ols_pkg::K_CONTAINS;
        end
        if (grow) begin
            if (p < 62) return ols_pkg::K_PUSH_BACK;
            if (p < 82) return ols_pkg::K_PUSH_FRONT;
            if (p < 90) return ols_pkg::K_POP_FRONT;
            return ols_pkg::K_REMOVE;
        end
        if (p < 47) return ols_pkg::K_PUSH_BACK;
        if (p < 55) return ols_pkg::K_PUSH_FRONT;
        if (p < 78) return ols_pkg::K_POP_FRONT;
        return ols_pkg::K_REMOVE;
    endfunction

    task automatic add_req(logic [ols_pkg::KIND_W-1:0] kind,
                           logic [ols_pkg::VAL_IO_W-1:0] value,
                           logic [ols_pkg::POS_W-1:0] position, int gap, bit drain);
        t_list_req rq;
        rq.kind = kind;
        rq.value = value;
        rq.position = position;
        rq.gap = gap;
        rq.drain = drain;
        pending_requests.insert(pending_requests.size(), rq);
    endtask

    // Request driver: a presented request is held until the block takes it.
    always @(negedge i_clk) begin
        t_list_req rq;
        if (i_rst_n && !(start && !req_taken)) begin
            if (pending_requests.size() == 0) begin
                start <= 1'b0;
            end else if (pending_requests[0].gap > 0) begin
                pending_requests[0].gap--;
                start <= 1'b0;
            end else if (pending_requests[0].drain && expected_results.size() != 0) begin
                start <= 1'b0;
            end else begin
                rq = pending_requests[0];
                pending_requests.delete(0);
                start <= 1'b1;
                i_kind <= rq.kind;
                i_value <= rq.value;
                i_position <= rq.position;
            end
        end
    end

    // Result checker and request predictor.
    always @(posedge i_clk) begin
        t_list_result want;
        t_list_req rq;
        if (i_rst_n) begin
            if (o_done) begin
                if (expected_results.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("%0t: result with no request waiting: status %0d count %0d",
                                 $realtime, o_status, o_entry_count);
                    end
                end else begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    checked_cnt++;
                    if (int'(o_status) < 5) begin
                        status_seen[o_status]++;
                    end
                    if (o_status !== want.status || o_found !== want.found ||
                        o_read_value !== want.read_value ||
                        o_entry_count !== want.entry_count) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $display({"%0t: result %0d mismatch: expected status %0d ",
                                      "found %0b read %h count %0d, got status %0d ",
                                      "found %0b read %h count %0d"},
                                     $realtime, checked_cnt, want.status, want.found,
                                     want.read_value, want.entry_count, o_status, o_found,
                                     o_read_value, o_entry_count);
                        end
                    end
                end
            end
            req_taken = start && !busy;
            if (req_taken) begin
                rq.kind = i_kind;
                rq.value = i_value;
                rq.position = i_position;
                rq.gap = 0;
                rq.drain = 1'b0;
                expected_results.insert(expected_results.size(), apply_list_request(rq));
                kind_seen[i_kind]++;
                accepted_cnt++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycle_cnt, expected_results.size());
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int c;
        bit grow;
        bit quiet;
        value_pool[0] = '0;
        value_pool[1] = '1;
        for (int i = 2; i < 8; i++) begin
            value_pool[i] = $urandom();
        end

        // Empty list corner cases first.
        add_req(ols_pkg::K_READ, '0, 4'd0, 0, 1'b0);
        add_req(ols_pkg::K_POP_FRONT, '0, '0, 0, 1'b0);
        add_req(ols_pkg::K_CONTAINS, '0, '0, rand_gap(), 1'b0);
        add_req(ols_pkg::K_REMOVE, '1, '0, 0, 1'b0);
        add_req(KIND_UNDEF_LO, '1, '1, 0, 1'b0);
        add_req(ols_pkg::K_PUSH_BACK, '0, '0, 0, 1'b0);
        add_req(ols_pkg::K_PUSH_FRONT, '1, '0, rand_gap(), 1'b0);
        add_req(ols_pkg::K_READ, '0, 4'd0, 0, 1'b0);
        add_req(ols_pkg::K_READ, '0, 4'd1, 0, 1'b0);
        add_req(ols_pkg::K_READ, '0, 4'd2, 0, 1'b0);
        add_req(ols_pkg::K_CONTAINS, '0, '0, 0, 1'b0);
        add_req(ols_pkg::K_CONTAINS, 32'h5a5a_a5a5, '0, 0, 1'b0);
        add_req(ols_pkg::K_REMOVE, 32'h5a5a_a5a5, '0, 0, 1'b0);
        // Fill to capacity, with a duplicate of zero in the middle.
        for (int i = 0; i < 14; i++) begin
            add_req((i % 2 == 0) ? ols_pkg::K_PUSH_BACK : ols_pkg::K_PUSH_FRONT,
                    (i == 7) ? 32'h0 : $urandom(), '0, 0, 1'b0);
        end
        add_req(ols_pkg::K_PUSH_BACK, 32'h1234_5678, '0, 0, 1'b0);
        add_req(ols_pkg::K_PUSH_FRONT, 32'h1234_5678, '0, 0, 1'b0);
        add_req(ols_pkg::K_READ, '0, 4'd15, 0, 1'b0);
        add_req(ols_pkg::K_REMOVE, '0, '0, rand_gap(), 1'b0);
        add_req(ols_pkg::K_CONTAINS, '0, '0, 0, 1'b0);
        add_req(ols_pkg::K_READ, '0, 4'd15, 0, 1'b0);
        add_req(KIND_UNDEF_HI, '0, '0, 0, 1'b0);

        for (int n = 0; n < RAND_ITEMS; n++) begin
            c = n / CHUNK;
            grow = (c % 2 == 0);
            quiet = (c == 3 || c == 6);
            add_req(pick_kind(grow), pick_value(), ols_pkg::POS_W'($urandom_range(0, 15)),
                    quiet ? 0 : rand_gap(), (n == 150 || n == 320));
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_requests.size() != 0 || start) begin
            @(posedge i_clk);
        end
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Checked %0d of %0d requests; kinds 0..7 seen: %0d %0d %0d %0d %0d %0d %0d %0d",
                 checked_cnt, accepted_cnt, kind_seen[0], kind_seen[1], kind_seen[2],
                 kind_seen[3], kind_seen[4], kind_seen[5], kind_seen[6], kind_seen[7]);
        $display("Statuses ok/full/empty/not found/range: %0d/%0d/%0d/%0d/%0d, mismatches %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], mismatch_cnt);
        if (mismatch_cnt == 0 && expected_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
